>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the blur/threshold RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define GBT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbt assertion failed");

// Next-cycle implication, disabled while in reset
`define GBT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbt assertion failed");

`endif

>>> rtl/gbt_pkg.sv
// ---------------------------------------------------------------------------
// gbt_pkg
// Types and constants shared by the blur/threshold front, queue and back.
// ---------------------------------------------------------------------------
package gbt_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [8:0]  THRESHOLD_RESET = 9'd145;
    localparam logic [10:0] WIDTH_RESET     = 11'd1024;

    // configuration register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_WIDTH     = 1'b1;

    // one classified column handed from front to back
    typedef struct packed {
        logic [9:0] csum;       // top + 2*middle + bottom
        logic       emit_left;  // result for the previous column
        logic       emit_edge;  // result for this column (row end)
        logic       row_end;    // clear the window after this beat
        logic [9:0] column;     // column of this beat, masked to 10 bits
    } job_t;

endpackage

>>> rtl/gaussian3x3_blur_threshold.sv
// ---------------------------------------------------------------------------
// gaussian3x3_blur_threshold
// Streaming 3x3 Gaussian blur with a colony threshold mark.
// ---------------------------------------------------------------------------
// Usage: pixels enter in raster order on in_valid/in_ready, one beat per
// pixel, with pad set for the zero flush row sent after the last frame row.
// Results leave on out_valid/out_ready: blurred_value, colony_mark, the
// out_column of the blurred pixel and last on the final result of a beat.
// The first row of a frame yields no results; each later row yields one
// result per pixel from the second pixel on, plus an extra one at row end.
// Configuration (threshold, image_width) is written on cfg_valid/cfg_ready,
// always ready; a width write restarts the stream position.
// An accepted pixel passes stage 1 and the column queue before its result
// reaches the output register. Throughput: one pixel per cycle while the
// receiver keeps up; the single result register issues the two row-end
// results one after the other, and the four-entry column queue absorbs it.
// Reset: stream position, queue and output clear; the line stores hold
// nothing until written and need no clearing pass.
// A stalled receiver fills the queue, then in_ready falls.
// ---------------------------------------------------------------------------
module gaussian3x3_blur_threshold
#(
    parameter int MAX_WIDTH = gbt_pkg::MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel,
    input  logic        pad,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  blurred_value,
    output logic        colony_mark,
    output logic [9:0]  out_column,
    output logic        last
);

    logic [8:0]    threshold_reg;
    logic [10:0]   image_width_reg;
    logic          restart;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    gbt_pkg::job_t push_data;
    gbt_pkg::job_t head;

    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && (cfg_index == gbt_pkg::REG_WIDTH);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= gbt_pkg::THRESHOLD_RESET;
            image_width_reg <= gbt_pkg::WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == gbt_pkg::REG_THRESHOLD)
            begin
                threshold_reg <= cfg_data[8:0];
            end
            else
            begin
                image_width_reg <= cfg_data;
            end
        end
    end

    gbt_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .image_width (image_width_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .pad         (pad),
        .push        (push),
        .push_data   (push_data),
        .queue_full  (q_full)
    );

    gbt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (restart),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    gbt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (restart),
        .threshold     (threshold_reg),
        .job_empty     (q_empty),
        .job           (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .blurred_value (blurred_value),
        .colony_mark   (colony_mark),
        .out_column    (out_column),
        .last          (last)
    );

endmodule

>>> rtl/gbt_queue.sv
// ---------------------------------------------------------------------------
// gbt_queue
// Small register FIFO decoupling the front from the back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gbt_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          flush,
    input  logic          push,
    input  gbt_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output gbt_pkg::job_t head
);

    localparam int DEPTH = gbt_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    gbt_pkg::job_t    entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;

    assign full  = (count_reg == CNTW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (flush)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `GBT_ASSERT_IMP(a_no_overflow, clk, rst_n, full, !push || pop)
    `GBT_ASSERT_IMP(a_no_underflow, clk, rst_n, empty, !pop)
    `GBT_ASSERT_NXT(a_count_grows, clk, rst_n, push && !pop && !flush,
                    count_reg == $past(count_reg) + 1'b1)

endmodule

>>> rtl/gbt_front.sv
// ---------------------------------------------------------------------------
// gbt_front
// Accepts pixels, tracks row/column, reads and updates the two line stores
// and classifies each beat into a column job for the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gbt_front
#(
    parameter int MAX_WIDTH = gbt_pkg::MAX_WIDTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          restart,
    input  logic [10:0]   image_width,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    pixel,
    input  logic          pad,
    output logic          push,
    output gbt_pkg::job_t push_data,
    input  logic          queue_full
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // line stores: [15:8] row two above, [7:0] row above
    logic [15:0]   line_mem [MAX_WIDTH];
    logic [15:0]   rd_reg;
    logic [15:0]   byp_data_reg;
    logic          byp_reg;
    logic [15:0]   rd_eff;
    logic [15:0]   wr_data;

    logic [CW-1:0] col_cnt_reg;
    logic [1:0]    rows_reg;
    logic [CW-1:0] w_last;
    logic [12:0]   width_ext;
    logic          col_last;
    logic          accept;
    logic [7:0]    px;

    logic          st1_valid_reg;
    logic [7:0]    st1_px_reg;
    logic [CW-1:0] st1_addr_reg;
    logic          st1_top_en_reg;
    logic          st1_mid_en_reg;
    logic          st1_left_reg;
    logic          st1_edge_reg;
    logic          st1_end_reg;
    logic [7:0]    top;
    logic [7:0]    mid;

    // width in use, clamped to 1..MAX_WIDTH, as a last-column index
    assign width_ext = {2'b00, image_width};
    always_comb
    begin
        if (width_ext == '0)
        begin
            w_last = '0;
        end
        else if (width_ext > 13'(MAX_WIDTH))
        begin
            w_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = CW'(width_ext - 13'd1);
        end
    end

    assign col_last = (col_cnt_reg == w_last);
    assign px       = pad ? 8'd0 : pixel;
    assign push     = st1_valid_reg && !queue_full;
    assign in_ready = !st1_valid_reg || !queue_full;
    assign accept   = in_valid && in_ready;

    // stream position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            rows_reg    <= '0;
        end
        else if (restart)
        begin
            col_cnt_reg <= '0;
            rows_reg    <= '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_cnt_reg <= '0;
                if (pad)
                begin
                    rows_reg <= '0;
                end
                else if (rows_reg != 2'd2)
                begin
                    rows_reg <= rows_reg + 2'd1;
                end
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + 1'b1;
            end
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st1_valid_reg <= 1'b1;
                byp_reg       <= push && (st1_addr_reg == col_cnt_reg);
            end
            else if (push)
            begin
                st1_valid_reg <= 1'b0;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st1_px_reg     <= px;
            st1_addr_reg   <= col_cnt_reg;
            st1_top_en_reg <= (rows_reg == 2'd2);
            st1_mid_en_reg <= (rows_reg != 2'd0);
            st1_left_reg   <= (rows_reg != 2'd0) && (col_cnt_reg != '0);
            st1_edge_reg   <= (rows_reg != 2'd0) && col_last;
            st1_end_reg    <= col_last;
            byp_data_reg   <= wr_data;
        end
    end

    // line store: read on accept, write back when the beat leaves stage 1
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            line_mem[st1_addr_reg] <= wr_data;
        end
        if (accept)
        begin
            rd_reg <= line_mem[col_cnt_reg];
        end
    end

    // forward a write that raced the read of the same entry
    assign rd_eff  = byp_reg ? byp_data_reg : rd_reg;
    assign wr_data = {rd_eff[7:0], st1_px_reg};
    assign top     = st1_top_en_reg ? rd_eff[15:8] : 8'd0;
    assign mid     = st1_mid_en_reg ? rd_eff[7:0] : 8'd0;

    // column job
    always_comb
    begin
        push_data.csum      = 10'(top) + {1'b0, mid, 1'b0} + 10'(st1_px_reg);
        push_data.emit_left = st1_left_reg;
        push_data.emit_edge = st1_edge_reg;
        push_data.row_end   = st1_end_reg;
        push_data.column    = 10'(st1_addr_reg);
    end

    `GBT_ASSERT_IMP(a_emit_needs_row, clk, rst_n, st1_valid_reg && !st1_mid_en_reg,
                    !st1_left_reg && !st1_edge_reg)
    `GBT_ASSERT_IMP(a_top_needs_mid, clk, rst_n, st1_valid_reg && st1_top_en_reg,
                    st1_mid_en_reg)
    `GBT_ASSERT_IMP(a_edge_is_end, clk, rst_n, st1_valid_reg && st1_edge_reg,
                    st1_end_reg)

endmodule

>>> rtl/gbt_back.sv
// ---------------------------------------------------------------------------
// gbt_back
// Holds the sliding window of column sums, forms the weighted 3x3 sum and
// drives the result register (none, one or two results per column job).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gbt_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          restart,
    input  logic [8:0]    threshold,
    input  logic          job_empty,
    input  gbt_pkg::job_t job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    blurred_value,
    output logic          colony_mark,
    output logic [9:0]    out_column,
    output logic          last
);

    logic [9:0]  prev1_reg;
    logic [9:0]  prev2_reg;
    logic        phase_reg;
    logic        phase_next;
    logic        out_valid_reg;
    logic [7:0]  value_reg;
    logic        mark_reg;
    logic [9:0]  column_reg;
    logic        last_reg;

    logic        load_ok;
    logic        load;
    logic        do_left;
    logic [9:0]  cs_a;
    logic [9:0]  cs_b;
    logic [9:0]  cs_c;
    logic [11:0] wsum;

    assign load_ok = !out_valid_reg || out_ready;

    // sequencing of the results of the head job
    always_comb
    begin
        pop        = 1'b0;
        load       = 1'b0;
        phase_next = phase_reg;
        do_left    = job.emit_left && !phase_reg;
        if (!job_empty)
        begin
            if (!job.emit_left && !job.emit_edge)
            begin
                pop = 1'b1;
            end
            else if (load_ok)
            begin
                load = 1'b1;
                if (do_left && job.emit_edge)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    pop        = 1'b1;
                    phase_next = 1'b0;
                end
            end
        end
    end

    // window selection and weighted sum
    always_comb
    begin
        if (do_left)
        begin
            cs_a = prev2_reg;
            cs_b = prev1_reg;
            cs_c = job.csum;
        end
        else
        begin
            cs_a = prev1_reg;
            cs_b = job.csum;
            cs_c = '0;
        end
        wsum = 12'(cs_a) + {1'b0, cs_b, 1'b0} + 12'(cs_c);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            prev1_reg     <= '0;
            prev2_reg     <= '0;
        end
        else if (restart)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            prev1_reg     <= '0;
            prev2_reg     <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                if (job.row_end)
                begin
                    prev1_reg <= '0;
                    prev2_reg <= '0;
                end
                else
                begin
                    prev2_reg <= prev1_reg;
                    prev1_reg <= job.csum;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg  <= wsum[11:4];
            mark_reg   <= ({1'b0, wsum} < {threshold, 4'b0000});
            column_reg <= do_left ? job.column - 10'd1 : job.column;
            last_reg   <= !(do_left && job.emit_edge);
        end
    end

    assign out_valid     = out_valid_reg;
    assign blurred_value = value_reg;
    assign colony_mark   = mark_reg;
    assign out_column    = column_reg;
    assign last          = last_reg;

    `GBT_ASSERT_IMP(a_phase_has_job, clk, rst_n, phase_reg, !job_empty)
    `GBT_ASSERT_IMP(a_phase_two_results, clk, rst_n, phase_reg,
                    job.emit_left && job.emit_edge)
    `GBT_ASSERT_IMP(a_load_only_when_free, clk, rst_n, load, load_ok)

endmodule

>>> sim/tb_gaussian3x3_blur_threshold.sv
// ---------------------------------------------------------------------------
// tb_gaussian3x3_blur_threshold
// Self-checking bench for the streaming 3x3 blur with colony mark.
// Pixel beats are driven in raster order with random gaps, and results are
// taken with random and long back-pressure. Each accepted beat is run through
// a local blur predictor, and each result is matched against the oldest
// expected one. Tests cover reset settings, edge values, width clamping,
// back-pressure and random frames of many shapes.
// ---------------------------------------------------------------------------
module tb_gaussian3x3_blur_threshold;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS  = 160;
    localparam int RESET_PROBE   = 48;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;

    typedef enum int {ROW_PIXELS, ROW_FLUSH, ROW_CUT} row_kind_t;

    typedef struct packed {
        logic [7:0] value;
        logic       mark;
        logic [9:0] column;
        logic       last;
    } blur_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  pixel;
    logic        pad;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  blurred_value;
    logic        colony_mark;
    logic [9:0]  out_column;
    logic        last;

    // predictor state
    bit [7:0]     line_above     [gbt_pkg::MAX_WIDTH];
    bit [7:0]     line_two_above [gbt_pkg::MAX_WIDTH];
    int           col_pos       = 0;
    int           rows_seen     = 0;
    int           older_colsum  = 0;
    int           newer_colsum  = 0;
    logic [8:0]   thr_setting   = gbt_pkg::THRESHOLD_RESET;
    logic [10:0]  width_setting = gbt_pkg::WIDTH_RESET;

    blur_result_t expected_results [$];

    int mismatch_count  = 0;
    int beats_sent      = 0;
    int idle_cycles     = 0;
    int rx_hold_request = 0;
    bit tx_idle_on      = 1'b1;
    bit rx_stall_on     = 1'b1;
    bit stray_pads_on   = 1'b0;

    gaussian3x3_blur_threshold uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel         (pixel),
        .pad           (pad),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .blurred_value (blurred_value),
        .colony_mark   (colony_mark),
        .out_column    (out_column),
        .last          (last)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------
    // Blur predictor
    // ---------------------------------------------------------------

    function automatic int row_length();
        if (width_setting == 11'd0)
            return 1;
        if (width_setting > gbt_pkg::MAX_WIDTH)
            return gbt_pkg::MAX_WIDTH;
        return int'(width_setting);
    endfunction

    function automatic blur_result_t blur_result(input int left, input int centre,
                                                 input int right, input int col,
                                                 input bit is_last);
        blur_result_t r;
        int           s;
        s        = left + 2 * centre + right;
        r.value  = s[11:4];
        r.mark   = (s < 16 * int'(thr_setting));
        r.column = col[9:0];
        r.last   = is_last;
        return r;
    endfunction

    // one accepted beat: update the line stores and window, queue results
    function automatic void predict_blur(input logic [7:0] value, input logic is_pad);
        int w;
        int c;
        int here;
        int top;
        int mid;
        int colsum;
        w    = row_length();
        here = is_pad ? 0 : int'(value);
        c    = (col_pos >= w) ? 0 : col_pos;
        top  = (rows_seen >= 2) ? int'(line_two_above[c]) : 0;
        mid  = (rows_seen >= 1) ? int'(line_above[c]) : 0;
        colsum = top + 2 * mid + here;
        line_two_above[c] = line_above[c];
        line_above[c]     = here[7:0];

        if (rows_seen >= 1)
        begin
            if (c >= 1)
                expected_results.push_back(
                    blur_result(older_colsum, newer_colsum, colsum, c - 1, c != w - 1));
            // row end: extra result with a zero right neighbour
            if (c == w - 1)
                expected_results.push_back(blur_result(newer_colsum, colsum, 0, c, 1'b1));
        end

        if (c == w - 1)
        begin
            older_colsum = 0;
            newer_colsum = 0;
            col_pos      = 0;
            if (is_pad)
                rows_seen = 0;
            else if (rows_seen < 2)
                rows_seen++;
        end
        else
        begin
            older_colsum = newer_colsum;
            newer_colsum = colsum;
            col_pos      = c + 1;
        end
    endfunction

    function automatic void apply_register_write(input logic index, input logic [10:0] value);
        if (index == gbt_pkg::REG_THRESHOLD)
            thr_setting = value[8:0];
        else
        begin
            // width change restarts the stream position
            width_setting = value;
            col_pos       = 0;
            rows_seen     = 0;
            older_colsum  = 0;
            newer_colsum  = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Shared helpers
    // ---------------------------------------------------------------

    // mostly no gap, sometimes short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s", $time, msg);
    endtask

    task automatic send_item(input logic [7:0] value, input logic is_pad);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        pad      <= is_pad;
        do @(posedge clk); while (!in_ready);
        predict_blur(value, is_pad);
        beats_sent++;
    endtask

    // fixed < 0 gives random pixels
    task automatic send_row(input row_kind_t kind, input int fixed);
        int         w;
        logic       is_pad;
        logic [7:0] value;
        w = row_length();
        for (int c = 0; c < w; c++)
        begin
            value  = (fixed < 0) ? rand_pixel() : fixed[7:0];
            is_pad = (kind == ROW_FLUSH) || (kind == ROW_CUT && c == w - 1) ||
                     (stray_pads_on && $urandom_range(0, 99) < 4);
            send_item(value, is_pad);
        end
    endtask

    // sender stops and waits for every outstanding result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // drained, then let beats that make no result clear the pipeline
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [10:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register_write(index, value);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // wide reset width: a long first row makes no result; then a small
    // frame runs at the reset threshold
    task automatic test_reset_values();
        for (int c = 0; c < RESET_PROBE; c++)
            send_item(rand_pixel(), 1'b0);
        write_reg(gbt_pkg::REG_WIDTH, 11'd4);
        send_row(ROW_PIXELS, -1);
        send_row(ROW_PIXELS, -1);
        send_row(ROW_PIXELS, -1);
        send_row(ROW_FLUSH, -1);
    endtask

    task automatic test_edge_values();
        // all-white interior sum equals sixteen times threshold: no mark
        write_reg(gbt_pkg::REG_THRESHOLD, 11'd255);
        write_reg(gbt_pkg::REG_WIDTH, 11'd3);
        send_row(ROW_PIXELS, 255);
        send_row(ROW_PIXELS, 255);
        send_row(ROW_PIXELS, 255);
        send_row(ROW_FLUSH, -1);
        // zero threshold, width zero behaves as one
        write_reg(gbt_pkg::REG_THRESHOLD, 11'd0);
        write_reg(gbt_pkg::REG_WIDTH, 11'd0);
        send_row(ROW_PIXELS, 255);
        send_row(ROW_PIXELS, 0);
        send_row(ROW_FLUSH, -1);
        // flush row with no frame open
        write_reg(gbt_pkg::REG_WIDTH, 11'd1);
        send_row(ROW_FLUSH, -1);
        // top threshold; frame ended by a padded last beat
        write_reg(gbt_pkg::REG_THRESHOLD, 11'd256);
        write_reg(gbt_pkg::REG_WIDTH, 11'd2);
        send_row(ROW_PIXELS, 0);
        send_row(ROW_PIXELS, 255);
        send_row(ROW_CUT, 255);
    endtask

    task automatic test_backpressure();
        write_reg(gbt_pkg::REG_WIDTH, 11'd8);
        write_reg(gbt_pkg::REG_THRESHOLD, 11'd128);
        tx_idle_on = 1'b0;
        // long receiver hold while the sender keeps offering
        rx_hold_request = LONG_HOLD;
        send_row(ROW_PIXELS, -1);
        send_row(ROW_PIXELS, -1);
        send_row(ROW_PIXELS, -1);
        send_row(ROW_FLUSH, -1);
        // sender pauses mid-row until everything has come out
        send_row(ROW_PIXELS, -1);
        for (int c = 0; c < 8; c++)
        begin
            if (c == 4)
                wait_drained();
            send_item(rand_pixel(), 1'b0);
        end
        send_row(ROW_FLUSH, -1);
        tx_idle_on = 1'b1;
    endtask

    // width above the maximum clamps to the maximum: the second row starts
    // after the maximum number of pixels
    task automatic test_width_clamp();
        write_reg(gbt_pkg::REG_WIDTH, 11'd2047);
        write_reg(gbt_pkg::REG_THRESHOLD, 11'h7FF);
        tx_idle_on = 1'b0;
        send_row(ROW_PIXELS, -1);
        for (int c = 0; c < 8; c++)
            send_item(rand_pixel(), 1'b0);
        tx_idle_on = 1'b1;
        // back to a narrow stream
        write_reg(gbt_pkg::REG_WIDTH, 11'd8);
    endtask

    task automatic test_random_frames();
        int         start;
        int         rows;
        int         shape;
        int         r;
        logic [10:0] w;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS)
        begin
            tx_idle_on    = ($urandom_range(0, 3) != 0);
            rx_stall_on   = ($urandom_range(0, 3) != 0);
            stray_pads_on = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) != 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    w = 11'd0;
                else if (r < 70)
                    w = 11'($urandom_range(1, 8));
                else if (r < 92)
                    w = 11'($urandom_range(9, 24));
                else
                    w = 11'($urandom_range(25, 70));
                write_reg(gbt_pkg::REG_WIDTH, w);
            end
            if ($urandom_range(0, 1) != 0)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    write_reg(gbt_pkg::REG_THRESHOLD, 11'd0);
                else if (r == 1)
                    write_reg(gbt_pkg::REG_THRESHOLD, 11'd256);
                else if (r == 2)
                    write_reg(gbt_pkg::REG_THRESHOLD, 11'($urandom_range(0, 2047)));
                else
                    write_reg(gbt_pkg::REG_THRESHOLD, 11'($urandom_range(60, 200)));
            end
            rows  = $urandom_range(1, 5);
            shape = $urandom_range(0, 9);
            for (int i = 0; i < rows; i++)
            begin
                if (shape == 7 && i == rows - 1)
                    send_row(ROW_CUT, -1);
                else
                    send_row(ROW_PIXELS, -1);
            end
            // mostly a proper flush; otherwise left open or flushed twice
            if (shape < 7)
                send_row(ROW_FLUSH, -1);
            else if (shape == 9)
            begin
                send_row(ROW_FLUSH, -1);
                send_row(ROW_FLUSH, -1);
            end
        end
        stray_pads_on = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result sink: random stalls, plus a long hold on request
    // ---------------------------------------------------------------
    initial
    begin : result_sink
        int hold;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_request > 0)
            begin
                hold            = rx_hold_request;
                rx_hold_request = 0;
            end
            else
                hold = rx_stall_on ? pick_gap() : 0;
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        blur_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                note_failure($sformatf("unexpected result: value %0d mark %0b column %0d last %0b",
                                       blurred_value, colony_mark, out_column, last));
            else
            begin
                want = expected_results.pop_front();
                if (blurred_value !== want.value || colony_mark !== want.mark ||
                    out_column !== want.column || last !== want.last)
                    note_failure($sformatf(
                        "result: exp value %0d mark %0b column %0d last %0b, got %0d %0b %0d %0b",
                        want.value, want.mark, want.column, want.last,
                        blurred_value, colony_mark, out_column, last));
            end
        end
    end

    // watchdog: too long without any beat on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : run
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = gbt_pkg::REG_THRESHOLD;
        cfg_data  = 11'd0;
        in_valid  = 1'b0;
        pixel     = 8'd0;
        pad       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_edge_values();
        test_backpressure();
        test_width_clamp();
        test_random_frames();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
